@@ src/rbp_pkg.sv @@
// rbp_pkg: shared types, constants and helper functions for the record batch parser
// no dependencies; used by every rbp module

package rbp_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_CRC_CHECK    = 1'b0;
  localparam logic REG_PAYLOAD_PASS = 1'b1;

  localparam logic [31:0] HDR_BYTES      = 32'd61;
  localparam logic [31:0] MIN_LENGTH     = 32'd49;
  localparam logic [31:0] LEN_OFFSET     = 32'd11;
  localparam logic [31:0] POS_LENGTH_END = 32'd11;
  localparam logic [31:0] POS_MAGIC      = 32'd16;
  localparam logic [31:0] POS_CRC_END    = 32'd20;
  localparam logic [31:0] POS_CRC_START  = 32'd21;
  localparam logic [31:0] POS_ATTR_END   = 32'd22;
  localparam logic [31:0] POS_COUNT_END  = 32'd60;
  localparam logic [7:0]  MAGIC_BYTE     = 8'd2;
  localparam logic [31:0] CRC_POLY       = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;

  localparam logic [3:0] FID_OFFSET     = 4'd0;
  localparam logic [3:0] FID_LENGTH     = 4'd1;
  localparam logic [3:0] FID_EPOCH      = 4'd2;
  localparam logic [3:0] FID_CRC        = 4'd3;
  localparam logic [3:0] FID_ATTRS      = 4'd4;
  localparam logic [3:0] FID_BASE_TS    = 4'd5;
  localparam logic [3:0] FID_MAX_TS     = 4'd6;
  localparam logic [3:0] FID_PRODUCER   = 4'd7;
  localparam logic [3:0] FID_PROD_EPOCH = 4'd8;
  localparam logic [3:0] FID_SEQUENCE   = 4'd9;
  localparam logic [3:0] FID_COUNT      = 4'd10;

  typedef enum logic [1:0] {
    KIND_FIELD   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NEG_LENGTH     = 3'd1,
    ST_TOO_SHORT      = 3'd2,
    ST_BAD_MAGIC      = 3'd3,
    ST_CRC_MISMATCH   = 3'd4,
    ST_NEG_COUNT      = 3'd5,
    ST_COUNT_EXCEEDS  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SX_16 = 2'd0,
    SX_32 = 2'd1,
    SX_64 = 2'd2
  } sext_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
    sext_t      sx;
  } field_info_t;

  typedef struct packed {
    logic crc_check_enable;
    logic payload_pass_enable;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_id;
    logic [63:0] value;
    status_t     status;
    logic        last;
    logic [5:0]  attr;
  } result_t;

  // reflected crc-32c, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // header field that completes at a byte position
  function automatic field_info_t field_lookup(input logic [5:0] pos);
    field_info_t f;
    f = '{hit: 1'b1, id: FID_OFFSET, sx: SX_64};
    case (pos)
      6'd7:    f = '{hit: 1'b1, id: FID_OFFSET,     sx: SX_64};
      6'd11:   f = '{hit: 1'b1, id: FID_LENGTH,     sx: SX_32};
      6'd15:   f = '{hit: 1'b1, id: FID_EPOCH,      sx: SX_32};
      6'd20:   f = '{hit: 1'b1, id: FID_CRC,        sx: SX_32};
      6'd22:   f = '{hit: 1'b1, id: FID_ATTRS,      sx: SX_16};
      6'd34:   f = '{hit: 1'b1, id: FID_BASE_TS,    sx: SX_64};
      6'd42:   f = '{hit: 1'b1, id: FID_MAX_TS,     sx: SX_64};
      6'd50:   f = '{hit: 1'b1, id: FID_PRODUCER,   sx: SX_64};
      6'd52:   f = '{hit: 1'b1, id: FID_PROD_EPOCH, sx: SX_16};
      6'd56:   f = '{hit: 1'b1, id: FID_SEQUENCE,   sx: SX_32};
      6'd60:   f = '{hit: 1'b1, id: FID_COUNT,      sx: SX_32};
      default: f = '{hit: 1'b0, id: FID_OFFSET,     sx: SX_64};
    endcase
    return f;
  endfunction

  function automatic logic [63:0] sext_field(input logic [63:0] acc, input sext_t sx);
    logic [63:0] v;
    case (sx)
      SX_16:   v = {{48{acc[15]}}, acc[15:0]};
      SX_32:   v = {{32{acc[31]}}, acc[31:0]};
      default: v = acc;
    endcase
    return v;
  endfunction

endpackage

@@ src/rbp_if.sv @@
// rbp_in_if / rbp_out_if: valid-ready channels of the record batch parser
// depends on nothing but plain logic types

interface rbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       resync;

  modport source (output valid, output data_byte, output resync, input ready);
  modport sink   (input valid, input data_byte, input resync, output ready);
endinterface

interface rbp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         field_id;
  logic signed [63:0] value;
  logic [2:0]         status;
  logic               last;
  logic [2:0]         codec;
  logic               ts_type;
  logic               transactional;
  logic               control_batch;

  modport source (output valid, output kind, output field_id, output value, output status,
                  output last, output codec, output ts_type, output transactional,
                  output control_batch, input ready);
  modport sink   (input valid, input kind, input field_id, input value, input status,
                  input last, input codec, input ts_type, input transactional,
                  input control_batch, output ready);
endinterface

@@ src/rbp_cfg_regs.sv @@
// rbp_cfg_regs: apb-style configuration registers of the record batch parser
// depends on rbp_pkg

module rbp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rbp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rbp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rbp_pkg::cfg_t                   cfg
);

  logic crc_en_r;
  logic crc_en_nxt;
  logic pass_en_r;
  logic pass_en_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    crc_en_nxt  = crc_en_r;
    pass_en_nxt = pass_en_r;
    if (wr_en) begin
      unique case (paddr[2])
        rbp_pkg::REG_CRC_CHECK:    crc_en_nxt  = pwdata[0];
        rbp_pkg::REG_PAYLOAD_PASS: pass_en_nxt = pwdata[0];
        default:                   crc_en_nxt  = crc_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r  <= 1'b1;
      pass_en_r <= 1'b1;
    end else begin
      crc_en_r  <= crc_en_nxt;
      pass_en_r <= pass_en_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      rbp_pkg::REG_CRC_CHECK:    prdata[0] = crc_en_r;
      rbp_pkg::REG_PAYLOAD_PASS: prdata[0] = pass_en_r;
      default:                   prdata[0] = 1'b0;
    endcase
  end

  assign cfg.crc_check_enable    = crc_en_r;
  assign cfg.payload_pass_enable = pass_en_r;

endmodule

@@ src/rbp_parse.sv @@
// rbp_parse: per-byte header parsing, crc-32c and end-of-batch checks
// depends on rbp_pkg; produces up to two results for each accepted byte

module rbp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             resync,
  input  rbp_pkg::cfg_t    cfg,
  output rbp_pkg::result_t res0,
  output rbp_pkg::result_t res1,
  output logic [1:0]       res_cnt
);

  logic [31:0] pos_r,  pos_nxt;
  logic [63:0] acc_r,  acc_nxt;
  logic [31:0] crc_r,  crc_nxt;
  logic [31:0] len_r,  len_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] cnt_r,  cnt_nxt;
  logic [5:0]  attr_r, attr_nxt;
  logic        hold_r, hold_nxt;

  logic [31:0] eff_pos, eff_crc, eff_len, eff_scrc, eff_cnt;
  logic [63:0] eff_acc;
  logic [5:0]  eff_attr;
  logic        eff_hold;

  logic [63:0] acc_upd;
  logic [31:0] crc_upd, len_upd, scrc_upd, cnt_upd;
  logic [5:0]  attr_upd;
  logic        in_hdr;
  logic        batch_end;
  logic        item_v;
  logic        stat_v;
  rbp_pkg::field_info_t finfo;
  rbp_pkg::status_t     err;
  rbp_pkg::status_t     end_st;
  rbp_pkg::status_t     stat_code;
  rbp_pkg::result_t     item;
  rbp_pkg::result_t     stat_item;

  always_comb begin
    // resync makes this byte the first of a fresh batch
    eff_pos  = resync ? 32'd0 : pos_r;
    eff_acc  = resync ? 64'd0 : acc_r;
    eff_crc  = resync ? rbp_pkg::CRC_INIT : crc_r;
    eff_len  = resync ? 32'd0 : len_r;
    eff_scrc = resync ? 32'd0 : scrc_r;
    eff_cnt  = resync ? 32'd0 : cnt_r;
    eff_attr = resync ? 6'd0 : attr_r;
    eff_hold = resync ? 1'b0 : hold_r;

    acc_upd = {eff_acc[55:0], data_byte};
    crc_upd = (eff_pos >= rbp_pkg::POS_CRC_START) ? rbp_pkg::crc_byte(eff_crc, data_byte)
                                                  : eff_crc;
    in_hdr  = eff_pos < rbp_pkg::HDR_BYTES;
    finfo   = rbp_pkg::field_lookup(eff_pos[5:0]);

    len_upd  = eff_len;
    scrc_upd = eff_scrc;
    cnt_upd  = eff_cnt;
    attr_upd = eff_attr;
    err      = rbp_pkg::ST_OK;
    if (in_hdr) begin
      if (eff_pos == rbp_pkg::POS_LENGTH_END) begin
        len_upd = acc_upd[31:0];
        if (acc_upd[31]) begin
          err = rbp_pkg::ST_NEG_LENGTH;
        end else if (acc_upd[31:0] < rbp_pkg::MIN_LENGTH) begin
          err = rbp_pkg::ST_TOO_SHORT;
        end
      end
      if (eff_pos == rbp_pkg::POS_MAGIC && acc_upd[7:0] != rbp_pkg::MAGIC_BYTE) begin
        err = rbp_pkg::ST_BAD_MAGIC;
      end
      if (eff_pos == rbp_pkg::POS_CRC_END) begin
        scrc_upd = acc_upd[31:0];
      end
      if (eff_pos == rbp_pkg::POS_ATTR_END) begin
        attr_upd = acc_upd[5:0];
      end
      if (eff_pos == rbp_pkg::POS_COUNT_END) begin
        cnt_upd = acc_upd[31:0];
      end
    end

    item_v         = 1'b0;
    item.kind      = rbp_pkg::KIND_FIELD;
    item.field_id  = rbp_pkg::FID_OFFSET;
    item.value     = '0;
    item.status    = rbp_pkg::ST_OK;
    item.last      = 1'b0;
    item.attr      = attr_upd;
    if (in_hdr && finfo.hit) begin
      item_v        = 1'b1;
      item.field_id = finfo.id;
      item.value    = rbp_pkg::sext_field(acc_upd, finfo.sx);
    end else if (!in_hdr && cfg.payload_pass_enable) begin
      item_v     = 1'b1;
      item.kind  = rbp_pkg::KIND_PAYLOAD;
      item.value = {56'd0, data_byte};
    end

    batch_end = (eff_pos >= rbp_pkg::POS_COUNT_END) &&
                ((eff_pos - rbp_pkg::LEN_OFFSET) == eff_len);

    priority if (cfg.crc_check_enable && (~crc_upd) != eff_scrc) begin
      end_st = rbp_pkg::ST_CRC_MISMATCH;
    end else if (cnt_upd[31]) begin
      end_st = rbp_pkg::ST_NEG_COUNT;
    end else if (attr_upd[2:0] == 3'd0 && cnt_upd > (eff_len - rbp_pkg::MIN_LENGTH)) begin
      end_st = rbp_pkg::ST_COUNT_EXCEEDS;
    end else begin
      end_st = rbp_pkg::ST_OK;
    end

    stat_v    = (err != rbp_pkg::ST_OK) || batch_end;
    stat_code = (err != rbp_pkg::ST_OK) ? err : end_st;

    stat_item.kind     = rbp_pkg::KIND_STATUS;
    stat_item.field_id = rbp_pkg::FID_OFFSET;
    stat_item.value    = '0;
    stat_item.status   = stat_code;
    stat_item.last     = 1'b1;
    stat_item.attr     = attr_upd;

    // results in order: field or payload item first, then status
    res0    = item_v ? item : stat_item;
    res1    = stat_item;
    res_cnt = eff_hold ? 2'd0 : ({1'b0, item_v} + {1'b0, stat_v});

    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    crc_nxt  = crc_r;
    len_nxt  = len_r;
    scrc_nxt = scrc_r;
    cnt_nxt  = cnt_r;
    attr_nxt = attr_r;
    hold_nxt = hold_r;
    if (accept && !eff_hold) begin
      if (stat_v) begin
        pos_nxt  = 32'd0;
        acc_nxt  = 64'd0;
        crc_nxt  = rbp_pkg::CRC_INIT;
        len_nxt  = 32'd0;
        scrc_nxt = 32'd0;
        cnt_nxt  = 32'd0;
        attr_nxt = 6'd0;
        hold_nxt = (stat_code != rbp_pkg::ST_OK);
      end else begin
        pos_nxt  = eff_pos + 32'd1;
        acc_nxt  = acc_upd;
        crc_nxt  = crc_upd;
        len_nxt  = len_upd;
        scrc_nxt = scrc_upd;
        cnt_nxt  = cnt_upd;
        attr_nxt = attr_upd;
        hold_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 32'd0;
      acc_r  <= 64'd0;
      crc_r  <= rbp_pkg::CRC_INIT;
      len_r  <= 32'd0;
      scrc_r <= 32'd0;
      cnt_r  <= 32'd0;
      attr_r <= 6'd0;
      hold_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      crc_r  <= crc_nxt;
      len_r  <= len_nxt;
      scrc_r <= scrc_nxt;
      cnt_r  <= cnt_nxt;
      attr_r <= attr_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

@@ src/rbp_outbuf.sv @@
// rbp_outbuf: two-entry result register between the parser and the result channel
// depends on rbp_pkg

module rbp_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rbp_pkg::result_t push0,
  input  rbp_pkg::result_t push1,
  input  logic [1:0]       push_cnt,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output rbp_pkg::result_t out_data
);

  rbp_pkg::result_t q0_r, q0_nxt;
  rbp_pkg::result_t q1_r, q1_nxt;
  logic [1:0]       n_r,  n_nxt;
  logic             pop;

  assign out_valid = (n_r != 2'd0);
  assign out_data  = q0_r;
  assign pop       = out_valid & out_ready;
  // a new request fits once the buffer drains in this cycle
  assign can_push  = (n_r == 2'd0) || (n_r == 2'd1 && pop);

  always_comb begin
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    n_nxt  = n_r;
    if (push) begin
      q0_nxt = push0;
      q1_nxt = push1;
      n_nxt  = push_cnt;
    end else if (pop) begin
      q0_nxt = q1_r;
      n_nxt  = n_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 2'd0;
    end else begin
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

@@ src/record_batch_v2_parser_core.sv @@
// record_batch_v2_parser_core: top level of the version-2 record batch parser
// depends on rbp_pkg, rbp_if, rbp_cfg_regs, rbp_parse and rbp_outbuf
//
//   channel   direction  handshake        carries
//   in_chan   sink       valid/ready      data_byte, resync
//   out_chan  source     valid/ready      kind, field_id, value, status, last, attr bits
//   apb       slave      psel/penable     crc_check_enable, payload_pass_enable
//
// one byte is accepted per cycle while can_push is high; header, status and payload results
// leave one per cycle while out_chan.ready is high, from a two-entry result register, so a
// byte with two results holds input; results and parser state update at the accepting edge
// reset (rst_n low, synchronous) clears the parser, error hold and result register and sets
// both configuration bits; out_chan stalls back up into in_chan through in_chan.ready

module record_batch_v2_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  rbp_in_if.sink                         in_chan,
  rbp_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rbp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rbp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  rbp_pkg::cfg_t    cfg;
  rbp_pkg::result_t res0;
  rbp_pkg::result_t res1;
  rbp_pkg::result_t out_data;
  logic [1:0]       res_cnt;
  logic             can_push;
  logic             accept;

  assign in_chan.ready = can_push;
  assign accept        = in_chan.valid & can_push;

  rbp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_chan.data_byte),
    .resync    (in_chan.resync),
    .cfg       (cfg),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  rbp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push0     (res0),
    .push1     (res1),
    .push_cnt  (res_cnt),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.kind          = out_data.kind;
  assign out_chan.field_id      = out_data.field_id;
  assign out_chan.value         = out_data.value;
  assign out_chan.status        = out_data.status;
  assign out_chan.last          = out_data.last;
  assign out_chan.codec         = out_data.attr[2:0];
  assign out_chan.ts_type       = out_data.attr[3];
  assign out_chan.transactional = out_data.attr[4];
  assign out_chan.control_batch = out_data.attr[5];

endmodule

@@ verif/record_batch_v2_parser_core_tb.sv @@
`timescale 1ns / 100ps
// record_batch_v2_parser_core_tb: self-checking bench for the record batch parser core
// drives byte batches and apb writes, checks every result; needs rbp_pkg, rbp_if, the core

module record_batch_v2_parser_core_tb;
  import rbp_pkg::*;

  localparam int LIMIT_NS     = 20_000_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASES       = 5;
  // per phase settings, bit p is phase p
  localparam logic [PHASES-1:0] PLAN_CRC  = 5'b10101;
  localparam logic [PHASES-1:0] PLAN_PASS = 5'b10011;

  typedef enum int {
    BT_OK, BT_BAD_CRC, BT_NEG_COUNT, BT_COUNT_OVER, BT_BAD_MAGIC,
    BT_SHORT, BT_NEG_LEN, BT_TRUNC, BT_NOISE, BT_NUM
  } batch_t;

  // n below zero: results come from the predictor
  typedef struct {
    logic [7:0] data;
    logic       rs;
    int         n;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rbp_in_if  in_if();
  rbp_out_if out_if();

  record_batch_v2_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // parser model state
  logic        m_crc_en;
  logic        m_pass_en;
  logic        m_hold;
  logic [31:0] m_pos;
  logic [31:0] m_crc;
  logic [31:0] m_len;
  logic [31:0] m_scrc;
  logic [31:0] m_count;
  logic [63:0] m_acc;
  logic [5:0]  m_attr;

  result_t    pending_results[$];
  dir_row_t   dir_tab[$];
  logic [7:0] batch_bytes[$];
  logic       dir_sel;
  int         dir_idx;
  logic       send_burst;
  int         fails;

  function automatic logic [31:0] crc32c_update(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [63:0] sign_extend(input logic [63:0] acc, input int nb);
    logic [63:0] keep;
    if (nb >= 8) return acc;
    keep = ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * nb));
    return acc[8 * nb - 1] ? (acc | ~keep) : (acc & keep);
  endfunction

  // byte count of the header field ending at pos, 0 where none ends
  function automatic int header_field(input logic [31:0] pos, output logic [3:0] id);
    id = FID_OFFSET;
    case (pos)
      32'd7:   begin id = FID_OFFSET;     return 8; end
      32'd11:  begin id = FID_LENGTH;     return 4; end
      32'd15:  begin id = FID_EPOCH;      return 4; end
      32'd20:  begin id = FID_CRC;        return 4; end
      32'd22:  begin id = FID_ATTRS;      return 2; end
      32'd34:  begin id = FID_BASE_TS;    return 8; end
      32'd42:  begin id = FID_MAX_TS;     return 8; end
      32'd50:  begin id = FID_PRODUCER;   return 8; end
      32'd52:  begin id = FID_PROD_EPOCH; return 2; end
      32'd56:  begin id = FID_SEQUENCE;   return 4; end
      32'd60:  begin id = FID_COUNT;      return 4; end
      default: return 0;
    endcase
  endfunction

  function automatic result_t mk_result(input kind_t kind, input logic [3:0] fid,
                                        input logic [63:0] val, input status_t st,
                                        input logic last, input logic [5:0] attr);
    result_t r;
    r.kind     = kind;
    r.field_id = fid;
    r.value    = val;
    r.status   = st;
    r.last     = last;
    r.attr     = attr;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("kind %0d fid %0d value %h status %0d last %0d attr %h",
                     r.kind, r.field_id, r.value, r.status, r.last, r.attr);
  endfunction

  function automatic void report(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endfunction

  function automatic void clear_parser();
    m_pos   = '0;
    m_acc   = '0;
    m_crc   = CRC_INIT;
    m_len   = '0;
    m_scrc  = '0;
    m_count = '0;
    m_attr  = '0;
  endfunction

  // advances the model by one accepted byte, queueing the results it gives when emit is set
  function automatic void parse_step(input logic [7:0] b, input logic rs, input logic emit);
    logic [31:0] pos;
    status_t     err;
    status_t     fin;
    logic [3:0]  fid;
    int          nb;
    result_t     r[$];
    if (rs) begin
      clear_parser();
      m_hold = 1'b0;
    end
    if (m_hold) return;
    pos   = m_pos;
    m_acc = {m_acc[55:0], b};
    if (pos >= POS_CRC_START) m_crc = crc32c_update(m_crc, b);
    err = ST_OK;
    if (pos < HDR_BYTES) begin
      case (pos)
        POS_LENGTH_END: begin
          m_len = m_acc[31:0];
          if (m_len[31]) err = ST_NEG_LENGTH;
          else if (m_len < MIN_LENGTH) err = ST_TOO_SHORT;
        end
        POS_MAGIC:     if (m_acc[7:0] != MAGIC_BYTE) err = ST_BAD_MAGIC;
        POS_CRC_END:   m_scrc = m_acc[31:0];
        POS_ATTR_END:  m_attr = m_acc[5:0];
        POS_COUNT_END: m_count = m_acc[31:0];
        default: ;
      endcase
      nb = header_field(pos, fid);
      if (nb != 0)
        r = {r, mk_result(KIND_FIELD, fid, sign_extend(m_acc, nb), ST_OK, 1'b0, m_attr)};
    end else if (m_pass_en) begin
      r = {r, mk_result(KIND_PAYLOAD, 4'd0, {56'd0, b}, ST_OK, 1'b0, m_attr)};
    end
    if (err != ST_OK) begin
      r = {r, mk_result(KIND_STATUS, 4'd0, 64'd0, err, 1'b1, m_attr)};
      clear_parser();
      m_hold = 1'b1;
    end else if (pos >= POS_COUNT_END && pos - LEN_OFFSET == m_len) begin
      fin = ST_OK;
      if (m_crc_en && (~m_crc) != m_scrc) fin = ST_CRC_MISMATCH;
      else if (m_count[31]) fin = ST_NEG_COUNT;
      else if (m_attr[2:0] == 3'd0 && m_count > m_len - MIN_LENGTH) fin = ST_COUNT_EXCEEDS;
      r = {r, mk_result(KIND_STATUS, 4'd0, 64'd0, fin, 1'b1, m_attr)};
      clear_parser();
      if (fin != ST_OK) m_hold = 1'b1;
    end else begin
      m_pos = pos + 1;
    end
    if (emit) pending_results = {pending_results, r};
  endfunction

  function automatic void add_row(input logic [7:0] data, input logic rs, input int n = -1,
                                  input result_t r0 = '0, input result_t r1 = '0);
    dir_row_t row;
    row.data = data;
    row.rs   = rs;
    row.n    = n;
    row.r0   = r0;
    row.r1   = r1;
    dir_tab = {dir_tab, row};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // top n bytes of v, most significant first
  function automatic void push_be(input logic [63:0] v, input int n);
    for (int k = 0; k < n; k++) batch_bytes = {batch_bytes, v[63 - 8 * k -: 8]};
  endfunction

  function automatic void put_word(input int idx, input logic [31:0] w);
    for (int k = 0; k < 4; k++) batch_bytes[idx + k] = w[31 - 8 * k -: 8];
  endfunction

  function automatic batch_t pick_batch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return BT_OK;
    return batch_t'(1 + (r - 50) % (int'(BT_NUM) - 1));
  endfunction

  // one complete batch with a valid crc, then damaged as the batch kind asks
  function automatic void build_batch(input batch_t kind);
    logic [31:0] plen;
    logic [31:0] blen;
    logic [31:0] cnt;
    logic [31:0] crc;
    logic [63:0] attrs;
    logic [7:0]  magic;
    plen  = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
    blen  = MIN_LENGTH + plen;
    attrs = pick64();
    if (kind == BT_COUNT_OVER) attrs[50:48] = 3'd0;
    case (kind)
      BT_NEG_COUNT:  cnt = $urandom | 32'h8000_0000;
      BT_COUNT_OVER: cnt = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF :
                           plen + 1 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 300));
      default:       cnt = (attrs[50:48] != 3'd0 && $urandom_range(0, 1)) ?
                           ($urandom & 32'h7FFF_FFFF) : $urandom_range(0, plen);
    endcase
    magic = MAGIC_BYTE;
    if (kind == BT_BAD_MAGIC) begin
      magic = 8'($urandom_range(0, 255));
      if (magic == MAGIC_BYTE) magic = ~MAGIC_BYTE;
    end
    batch_bytes.delete();
    push_be(pick64(), 8);
    push_be({blen, 32'd0}, 4);
    push_be(pick64(), 4);
    batch_bytes = {batch_bytes, magic};
    push_be(64'd0, 4);
    push_be(attrs, 2);
    push_be(pick64(), 4);
    push_be(pick64(), 8);
    push_be(pick64(), 8);
    push_be(pick64(), 8);
    push_be(pick64(), 2);
    push_be(pick64(), 4);
    push_be({cnt, 32'd0}, 4);
    repeat (plen) batch_bytes = {batch_bytes, 8'($urandom_range(0, 255))};
    crc = CRC_INIT;
    for (int i = POS_CRC_START; i < batch_bytes.size(); i++)
      crc = crc32c_update(crc, batch_bytes[i]);
    crc = ~crc;
    if (kind == BT_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    put_word(POS_MAGIC + 1, crc);
    if (kind == BT_SHORT) put_word(POS_LENGTH_END - 3, $urandom_range(0, MIN_LENGTH - 1));
    if (kind == BT_NEG_LEN) put_word(POS_LENGTH_END - 3, $urandom | 32'h8000_0000);
  endfunction

  // request on the byte channel; rs is forced on a first byte while errored, and at random
  task automatic send_byte(input logic [7:0] b, input logic rs, input logic first,
                           input logic dsel, input int didx);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.resync    <= rs | (first & (m_hold | ($urandom_range(0, 3) == 0)));
    dir_sel         <= dsel;
    dir_idx         <= didx;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic cfg_write(input logic idx, input logic val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CRC_CHECK) m_crc_en = val;
    else m_pass_en = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    int  n;
    int  cnt;
    logic burst;
    out_if.ready = 1'b0;
    cnt   = 0;
    burst = 1'b0;
    @(negedge clk);
    forever begin
      if (cnt % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      cnt++;
      n = burst ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_if.valid));
      @(negedge clk);
    end
  end

  // results checked before the byte taken at the same edge is predicted
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = mk_result(kind_t'(out_if.kind), out_if.field_id, out_if.value,
                        status_t'(out_if.status), out_if.last,
                        {out_if.control_batch, out_if.transactional,
                         out_if.ts_type, out_if.codec});
        if (pending_results.size() == 0) begin
          report({"unexpected result: ", show(got)});
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            report($sformatf("result mismatch: expected %s, got %s", show(want), show(got)));
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (dir_sel && dir_tab[dir_idx].n >= 0) begin
          parse_step(in_if.data_byte, in_if.resync, 1'b0);
          if (dir_tab[dir_idx].n > 0)
            pending_results = {pending_results, dir_tab[dir_idx].r0};
          if (dir_tab[dir_idx].n > 1)
            pending_results = {pending_results, dir_tab[dir_idx].r1};
        end else begin
          parse_step(in_if.data_byte, in_if.resync, 1'b1);
        end
      end
    end
  end

  initial begin
    int     sent;
    int     nsend;
    int     ndone;
    batch_t kind;
    logic   force_rs;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.resync    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    dir_sel         = 1'b0;
    dir_idx         = 0;
    send_burst      = 1'b0;
    fails           = 0;
    m_crc_en        = 1'b1;
    m_pass_en       = 1'b1;
    m_hold          = 1'b0;
    clear_parser();

    // minimum offset, then a length one below the minimum
    add_row(8'h80, 1'b1);
    repeat (6) add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1,
            mk_result(KIND_FIELD, FID_OFFSET, 64'h8000_0000_0000_0000, ST_OK, 1'b0, 6'd0));
    repeat (3) add_row(8'h00, 1'b0);
    add_row(8'h30, 1'b0, 2,
            mk_result(KIND_FIELD, FID_LENGTH, 64'd48, ST_OK, 1'b0, 6'd0),
            mk_result(KIND_STATUS, 4'd0, 64'd0, ST_TOO_SHORT, 1'b1, 6'd0));
    // dropped while errored
    add_row(8'hFF, 1'b0, 0);
    // resync, maximum offset, negative length
    add_row(8'h7F, 1'b1);
    repeat (6) add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0, 1,
            mk_result(KIND_FIELD, FID_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF, ST_OK, 1'b0, 6'd0));
    repeat (3) add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0, 2,
            mk_result(KIND_FIELD, FID_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK, 1'b0, 6'd0),
            mk_result(KIND_STATUS, 4'd0, 64'd0, ST_NEG_LENGTH, 1'b1, 6'd0));

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_byte(dir_tab[i].data, dir_tab[i].rs, 1'b0, 1'b1, i);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      cfg_write(REG_CRC_CHECK, PLAN_CRC[p]);
      cfg_write(REG_PAYLOAD_PASS, PLAN_PASS[p]);
      sent     = 0;
      ndone    = 0;
      force_rs = 1'b1;
      while (sent < RANDOM_ITEMS / PHASES) begin
        // batch kinds in order at the start of each phase, then weighted draws
        kind = (ndone < int'(BT_NUM)) ? batch_t'(ndone) : pick_batch();
        ndone++;
        send_burst = ($urandom_range(0, 3) == 0);
        if (kind == BT_NOISE) begin
          nsend = $urandom_range(1, 8);
          repeat (nsend) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 0);
          force_rs = 1'b1;
        end else begin
          build_batch(kind);
          case (kind)
            BT_SHORT, BT_NEG_LEN: nsend = POS_LENGTH_END + 1 + $urandom_range(0, 3);
            BT_BAD_MAGIC:         nsend = POS_MAGIC + 1 + $urandom_range(0, 3);
            BT_TRUNC:             nsend = $urandom_range(1, batch_bytes.size() - 1);
            default:              nsend = batch_bytes.size();
          endcase
          for (int i = 0; i < nsend; i++)
            send_byte(batch_bytes[i], force_rs && i == 0, i == 0, 1'b0, 0);
          force_rs = (kind == BT_TRUNC);
        end
        sent += nsend;
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rbp_pkg.sv
src/rbp_if.sv
src/rbp_cfg_regs.sv
src/rbp_parse.sv
src/rbp_outbuf.sv
src/record_batch_v2_parser_core.sv
verif/record_batch_v2_parser_core_tb.sv
